>>> hdl/alpha_bounding_box_trim_macros.svh
// Assertion macros used by the checker of the alpha bounding box trimmer.
`ifndef ALPHA_BOUNDING_BOX_TRIM_MACROS_SVH
`define ALPHA_BOUNDING_BOX_TRIM_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define ABBT_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define ABBT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/abbt_pkg.sv
// Types, constants and helper functions of the alpha bounding box trimmer.
`timescale 1ns / 1ps

package abbt_pkg;

  localparam int MaxDim = 4096;
  localparam int DimW = 13;
  localparam int CntW = 12;
  localparam int EdgeW = DimW + 1;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW = 2;
  localparam int QueueCntW = QueuePtrW + 1;

  // Configuration register indexes.
  localparam logic CFG_FRAME_WIDTH = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // One classified pixel, passed from the front end to the back end.
  typedef struct packed {
    logic            opaque;
    logic            last;
    logic [CntW-1:0] col;
    logic [CntW-1:0] row;
  } pix_t;

  // Frame geometry and the restart strobe that follows a register write.
  typedef struct packed {
    logic            restart;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } frame_cfg_t;

  // Result box; the first member sits in the highest bits.
  typedef struct packed {
    logic [EdgeW-1:0] high_edge;
    logic [EdgeW-1:0] low_edge;
    logic [EdgeW-1:0] right_edge;
    logic [EdgeW-1:0] left_edge;
  } box_t;

  // A size of zero counts as one, anything above the maximum as the maximum.
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Twice the coordinate minus the size, wrapped to the edge width.
  function automatic logic [EdgeW-1:0] half_edge(input logic [DimW-1:0] coord,
                                                 input logic [DimW-1:0] size);
    return {coord, 1'b0} - {1'b0, size};
  endfunction

endpackage

>>> hdl/abbt_front.sv
// Front end: configuration registers, input handshake and raster position tracking.
`timescale 1ns / 1ps

module abbt_front
  import abbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [DimW-1:0]  cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output pix_t             q_item,
  output frame_cfg_t       frame_cfg
);

  logic [DimW-1:0] w_r, w_nxt;
  logic [DimW-1:0] h_r, h_nxt;
  logic            restart_r, restart_nxt;
  logic [CntW-1:0] col_r, col_nxt;
  logic [CntW-1:0] row_r, row_nxt;
  logic            last_col;
  logic            last_row;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  assign last_col = ({1'b0, col_r} == (w_r - DimW'(1)));
  assign last_row = ({1'b0, row_r} == (h_r - DimW'(1)));

  assign q_item.opaque = (in_tdata != 8'd0);
  assign q_item.last   = last_col && last_row;
  assign q_item.col    = col_r;
  assign q_item.row    = row_r;

  assign frame_cfg.restart = restart_r;
  assign frame_cfg.w       = w_r;
  assign frame_cfg.h       = h_r;

  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    restart_nxt = 1'b0;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (q_push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CntW'(1);
      end else begin
        col_nxt = col_r + CntW'(1);
      end
    end
    // Any register write starts a fresh frame with the new size.
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  w_nxt = eff_dim(cfg_data);
        CFG_FRAME_HEIGHT: h_nxt = eff_dim(cfg_data);
        default: ;
      endcase
      restart_nxt = 1'b1;
      col_nxt     = '0;
      row_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= DimW'(MaxDim);
      h_r       <= DimW'(MaxDim);
      restart_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      restart_r <= restart_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

>>> hdl/abbt_queue.sv
// Short first-in first-out queue of classified pixels between front and back end.
`timescale 1ns / 1ps

module abbt_queue
  import abbt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pix_t push_item,
  output logic full,
  input  logic pop,
  output logic empty,
  output pix_t pop_item
);

  pix_t                 entry_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueueCntW-1:0] count_r, count_nxt;

  assign full     = (count_r == QueueCntW'(QueueDepth));
  assign empty    = (count_r == '0);
  assign pop_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QueuePtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QueuePtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + QueueCntW'(push) - QueueCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/abbt_back.sv
// Back end: bounding box accumulation and the registered result stage.
`timescale 1ns / 1ps

module abbt_back
  import abbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  frame_cfg_t       frame_cfg,
  input  logic             q_empty,
  input  pix_t             q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tuser
);

  logic [DimW-1:0] min_col_r, min_col_nxt;
  logic [DimW-1:0] max_col_end_r, max_col_end_nxt;
  logic [DimW-1:0] min_row_r, min_row_nxt;
  logic [DimW-1:0] max_row_end_r, max_row_end_nxt;
  logic            seen_r, seen_nxt;
  logic            out_valid_r, out_valid_nxt;
  box_t            out_box_r, out_box_nxt;
  logic            out_clear_r, out_clear_nxt;

  logic [DimW-1:0] col_w, row_w, col_end, row_end;
  logic [DimW-1:0] min_col_upd, max_col_end_upd, min_row_upd, max_row_end_upd;
  logic            seen_upd;

  // A pixel moves on only when the result register is free or being emptied.
  assign q_pop = !q_empty && (!out_valid_r || out_tready);

  assign col_w   = {1'b0, q_item.col};
  assign row_w   = {1'b0, q_item.row};
  assign col_end = col_w + DimW'(1);
  assign row_end = row_w + DimW'(1);

  always_comb begin
    min_col_upd     = (q_item.opaque && col_w < min_col_r) ? col_w : min_col_r;
    max_col_end_upd = (q_item.opaque && col_end > max_col_end_r) ? col_end : max_col_end_r;
    min_row_upd     = (q_item.opaque && row_w < min_row_r) ? row_w : min_row_r;
    max_row_end_upd = (q_item.opaque && row_end > max_row_end_r) ? row_end : max_row_end_r;
    seen_upd        = seen_r || q_item.opaque;
  end

  always_comb begin
    min_col_nxt     = min_col_r;
    max_col_end_nxt = max_col_end_r;
    min_row_nxt     = min_row_r;
    max_row_end_nxt = max_row_end_r;
    seen_nxt        = seen_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_box_nxt     = out_box_r;
    out_clear_nxt   = out_clear_r;
    if (q_pop) begin
      if (q_item.last) begin
        out_box_nxt.left_edge  = half_edge(min_col_upd, frame_cfg.w);
        out_box_nxt.right_edge = half_edge(max_col_end_upd, frame_cfg.w);
        out_box_nxt.low_edge   = half_edge(min_row_upd, frame_cfg.h);
        out_box_nxt.high_edge  = half_edge(max_row_end_upd, frame_cfg.h);
        out_clear_nxt          = !seen_upd;
        out_valid_nxt          = 1'b1;
      end else begin
        min_col_nxt     = min_col_upd;
        max_col_end_nxt = max_col_end_upd;
        min_row_nxt     = min_row_upd;
        max_row_end_nxt = max_row_end_upd;
        seen_nxt        = seen_upd;
      end
    end
    // The box starts over after each frame and after every register write.
    if ((q_pop && q_item.last) || frame_cfg.restart) begin
      min_col_nxt     = frame_cfg.w;
      max_col_end_nxt = '0;
      min_row_nxt     = frame_cfg.h;
      max_row_end_nxt = '0;
      seen_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_col_r     <= DimW'(MaxDim);
      max_col_end_r <= '0;
      min_row_r     <= DimW'(MaxDim);
      max_row_end_r <= '0;
      seen_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      min_col_r     <= min_col_nxt;
      max_col_end_r <= max_col_end_nxt;
      min_row_r     <= min_row_nxt;
      max_row_end_r <= max_row_end_nxt;
      seen_r        <= seen_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_box_r   <= out_box_nxt;
    out_clear_r <= out_clear_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_box_r;
  assign out_tuser  = out_clear_r;

endmodule

>>> hdl/alpha_bounding_box_trim.sv
// Top level of the alpha bounding box trimmer.
`timescale 1ns / 1ps
// The input stream carries one alpha byte per transfer, in raster order with
// the top row first. Frame width and height are set through the write port
// (index 0 width, index 1 height); a write restarts the frame and should be
// made while the block is idle. Sizes of zero count as one, sizes above 4096
// count as 4096.
// One result transfer follows the last pixel of every frame: the trimmed box
// edges in half-pixel units measured from the frame middle, and a flag on
// tuser that is set when the whole frame was transparent.
// Throughput is one pixel per clock while the pixel queue has room. The
// transfer of the last pixel writes it into the queue; once the result
// register is free or being emptied, it is taken through the box update
// into the result register.
// When the receiver stalls, the result register holds its value and the
// back end stops draining the four-entry pixel queue; the input stalls only
// once that queue is full. Synchronous reset sets both sizes to 4096 and
// empties the queue and the result register.

module alpha_bounding_box_trim
  import abbt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_index,
  input  logic [DimW-1:0] cfg_data,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] alpha
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [55:0]     out_tdata,  // [13:0] left_edge, [27:14] right_edge,
                                      // [41:28] low_edge, [55:42] high_edge
  output logic            out_tuser   // [0] all_clear
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  pix_t       q_in_item;
  pix_t       q_out_item;
  frame_cfg_t frame_cfg;

  abbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item),
    .frame_cfg (frame_cfg)
  );

  abbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_out_item)
  );

  abbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_cfg  (frame_cfg),
    .q_empty    (q_empty),
    .q_item     (q_out_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hdl/abbt_checker.sv
// Port-level checker of the alpha bounding box trimmer and its bind statement.
`timescale 1ns / 1ps
`include "alpha_bounding_box_trim_macros.svh"

module abbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  `ABBT_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `ABBT_ASSERT_NEXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A transparent frame reports the untouched start box, which is symmetric.
  `ABBT_ASSERT_NOW(a_clear_box, out_tvalid && out_tuser, (out_tdata[13:0] == 14'd0 - out_tdata[27:14]) && (out_tdata[41:28] == 14'd0 - out_tdata[55:42]), "transparent frame box is not symmetric")

  // With any opaque pixel the box has a positive extent in both directions.
  `ABBT_ASSERT_NOW(a_box_order, out_tvalid && !out_tuser, ($signed(out_tdata[13:0]) < $signed(out_tdata[27:14])) && ($signed(out_tdata[41:28]) < $signed(out_tdata[55:42])), "box edges out of order")

endmodule

bind alpha_bounding_box_trim abbt_checker u_abbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> dv/alpha_bounding_box_trim_tb.sv
// Self-checking testbench for the alpha bounding box trimmer, with a predictor and stalls on both sides.
`timescale 1ns / 1ps

module alpha_bounding_box_trim_tb;
  import abbt_pkg::*;

  localparam int SmallPixels = 1600;
  localparam int SettleCycles = 12;
  localparam int LongHold = 300;
  localparam int CycleLimit = 800000;

  typedef struct packed {
    logic [EdgeW-1:0] left_edge;
    logic [EdgeW-1:0] right_edge;
    logic [EdgeW-1:0] low_edge;
    logic [EdgeW-1:0] high_edge;
    logic             all_clear;
  } trim_box_t;

  typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARELY} ready_mode_e;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_wr_en = 1'b0;
  logic            cfg_index = 1'b0;
  logic [DimW-1:0] cfg_data = '0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [7:0]      in_tdata = '0;    // [7:0] alpha
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [55:0]     out_tdata;        // [13:0] left_edge, [27:14] right_edge,
                                     // [41:28] low_edge, [55:42] high_edge
  logic            out_tuser;        // [0] all_clear

  alpha_bounding_box_trim u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]  alpha_q[$];
  trim_box_t   boxes_due[$];
  int          errors = 0;

  bit          calm = 1'b0;
  ready_mode_e ready_mode = READY_ALWAYS;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          gap_left = 0;
  int          burst_left = 0;

  // Predictor state: register contents, raster position and box so far.
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  int              col_pos;
  int              row_pos;
  int              first_col;
  int              col_end;
  int              first_row;
  int              row_end;
  bit              any_opaque;

  function automatic int clamp_size(logic [DimW-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DimW'(MaxDim)) return MaxDim;
    return int'(raw);
  endfunction

  function automatic logic [EdgeW-1:0] half_pixels(int coord, int size);
    return EdgeW'(2 * coord - size);
  endfunction

  function void restart_box();
    col_pos = 0;
    row_pos = 0;
    first_col = clamp_size(width_reg);
    col_end = 0;
    first_row = clamp_size(height_reg);
    row_end = 0;
    any_opaque = 1'b0;
  endfunction

  function void take_register(logic idx, logic [DimW-1:0] val);
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
    restart_box();
  endfunction

  function void track_alpha(logic [7:0] alpha);
    int w;
    int h;
    trim_box_t box;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    if (alpha != 8'd0) begin
      any_opaque = 1'b1;
      if (col_pos < first_col) first_col = col_pos;
      if (col_pos + 1 > col_end) col_end = col_pos + 1;
      if (row_pos < first_row) first_row = row_pos;
      if (row_pos + 1 > row_end) row_end = row_pos + 1;
    end
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < h) begin
        row_pos++;
      end else begin
        box.left_edge = half_pixels(first_col, w);
        box.right_edge = half_pixels(col_end, w);
        box.low_edge = half_pixels(first_row, h);
        box.high_edge = half_pixels(row_end, h);
        box.all_clear = !any_opaque;
        boxes_due.push_back(box);
        restart_box();
      end
    end
  endfunction

  // Sender: bursts of random length separated by random gaps, unless calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      gap_left = 0;
      burst_left = 0;
      width_reg = DimW'(MaxDim);
      height_reg = DimW'(MaxDim);
      restart_box();
    end else begin
      if (cfg_wr_en) take_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) track_alpha(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 && !calm) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (alpha_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= alpha_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off runs once, counted here, while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_left != 0) begin
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_HALF:   out_tready <= 1'($urandom_range(0, 1));
        READY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        default:      out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic check_field(string field, logic [EdgeW-1:0] want, logic [EdgeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      errors++;
    end
  endtask

  trim_box_t want_box;
  trim_box_t got_box;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_box.left_edge = out_tdata[13:0];
      got_box.right_edge = out_tdata[27:14];
      got_box.low_edge = out_tdata[41:28];
      got_box.high_edge = out_tdata[55:42];
      got_box.all_clear = out_tuser;
      if (boxes_due.size() == 0) begin
        $display("%0t: result transfer with none expected, got tdata %h tuser %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want_box = boxes_due.pop_front();
        check_field("left_edge", want_box.left_edge, got_box.left_edge);
        check_field("right_edge", want_box.right_edge, got_box.right_edge);
        check_field("low_edge", want_box.low_edge, got_box.low_edge);
        check_field("high_edge", want_box.high_edge, got_box.high_edge);
        check_field("all_clear", EdgeW'(want_box.all_clear), EdgeW'(got_box.all_clear));
      end
    end
  end

  // Register writes are made only with the block drained; a write restarts the frame.
  task automatic write_reg(logic idx, logic [DimW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every queued pixel has gone and every box has arrived, then
  // lets the pixel queue inside the block empty as well.
  task automatic wait_drained();
    @(negedge clk);
    while (alpha_q.size() != 0 || in_tvalid || boxes_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic push_frame(int w, int h);
    int n;
    int pattern;
    int spot;
    int density;
    logic [7:0] alpha;
    n = w * h;
    pattern = $urandom_range(0, 7);
    spot = $urandom_range(0, n - 1);
    density = $urandom_range(2, 16);
    for (int i = 0; i < n; i++) begin
      case (pattern)
        0:       alpha = 8'd0;
        1:       alpha = 8'($urandom_range(1, 255));
        2:       alpha = (i == spot) ? 8'($urandom_range(1, 255)) : 8'd0;
        default: alpha = ($urandom_range(0, density - 1) == 0) ?
                         8'($urandom_range(1, 255)) : 8'd0;
      endcase
      alpha_q.push_back(alpha);
    end
  endtask

  function automatic logic [DimW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DimW'(1);
      default: return DimW'($urandom_range(2, 8));
    endcase
  endfunction

  initial begin
    int phase;
    int frames;
    int w;
    int h;
    int n;
    int which;
    int stray;
    int small_sent;
    bit big;
    bit was_big;
    logic [DimW-1:0] raw_w;
    logic [DimW-1:0] raw_h;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sizes of zero count as one, so every pixel closes a frame.
    write_reg(CFG_FRAME_WIDTH, '0);
    write_reg(CFG_FRAME_HEIGHT, '0);
    alpha_q.push_back(8'h00);
    alpha_q.push_back(8'hFF);
    alpha_q.push_back(8'h01);
    alpha_q.push_back(8'h80);
    alpha_q.push_back(8'h7F);
    alpha_q.push_back(8'h00);
    wait_drained();

    // A transparent frame, then a frame cut short by a register write.
    write_reg(CFG_FRAME_WIDTH, DimW'(3));
    write_reg(CFG_FRAME_HEIGHT, DimW'(2));
    repeat (6) alpha_q.push_back(8'h00);
    alpha_q.push_back(8'h40);
    alpha_q.push_back(8'h00);
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, DimW'(2));
    alpha_q.push_back(8'h00);
    alpha_q.push_back(8'h00);
    alpha_q.push_back(8'h00);
    alpha_q.push_back(8'hFF);
    alpha_q.push_back(8'hFF);
    alpha_q.push_back(8'h00);
    alpha_q.push_back(8'h00);
    alpha_q.push_back(8'h00);
    raw_w = DimW'(2);
    raw_h = DimW'(2);

    phase = 0;
    small_sent = 0;
    was_big = 1'b0;
    while (small_sent < SmallPixels) begin
      wait_drained();
      big = (phase == 4) || (phase == 9);
      if (phase == 4) begin
        raw_w = DimW'(4097);
        raw_h = DimW'(1);
        which = 2;
      end else if (phase == 9) begin
        raw_w = DimW'(1);
        raw_h = '1;
        which = 2;
      end else if (phase == 2) begin
        raw_w = DimW'(8);
        raw_h = DimW'(8);
        which = 2;
      end else begin
        which = was_big ? 2 : $urandom_range(0, 2);
        if (which != 1) raw_w = pick_size();
        if (which != 0) raw_h = pick_size();
      end
      if (which != 1) write_reg(CFG_FRAME_WIDTH, raw_w);
      if (which != 0) write_reg(CFG_FRAME_HEIGHT, raw_h);

      w = clamp_size(raw_w);
      h = clamp_size(raw_h);
      n = w * h;
      calm = big || (phase == 2) || ($urandom_range(0, 4) == 0);
      ready_mode = calm ? READY_ALWAYS : ready_mode_e'($urandom_range(0, 3));
      // Oversized registers clamp to the maximum; only a short run of such a
      // frame is sent, to show that no frame closes early.
      frames = big ? 0 : ((phase == 2) ? 5 : $urandom_range(1, 6));
      // The input must back up behind the stalled result here.
      if (phase == 2) hold_req = 1'b1;
      repeat (frames) push_frame(w, h);

      // Now and then a broken frame, abandoned at the next register write.
      stray = 0;
      if (big || (n > 1 && $urandom_range(0, 5) == 0)) begin
        stray = big ? $urandom_range(64, 128) : $urandom_range(1, n - 1);
        repeat (stray) begin
          alpha_q.push_back(($urandom_range(0, 1) == 0) ?
                            8'd0 : 8'($urandom_range(1, 255)));
        end
      end
      small_sent += frames * n + stray;
      was_big = big;
      phase++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && boxes_due.size() == 0) begin
      $display("[alpha_bounding_box_trim] OK");
    end else begin
      $display("[alpha_bounding_box_trim] ERROR");
    end
    $finish;
  end

  initial begin
    int watch_cycles;
    for (watch_cycles = 0; watch_cycles < CycleLimit; watch_cycles++) @(posedge clk);
    $display("[alpha_bounding_box_trim] ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/abbt_pkg.sv
hdl/abbt_front.sv
hdl/abbt_queue.sv
hdl/abbt_back.sv
hdl/alpha_bounding_box_trim.sv
hdl/abbt_checker.sv
dv/alpha_bounding_box_trim_tb.sv
